// ===== hw/rtl/stable_priority_queue_decrease_key_macros.svh =====
// Assertion macros used by the checker file.
`ifndef STABLE_PRIORITY_QUEUE_DECREASE_KEY_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_DECREASE_KEY_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define SPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication checked in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== hw/rtl/spq_pkg.sv =====
// Package with shared constants and types of the priority queue.
package spq_pkg;
    localparam int CAPACITY_DEF = 16;
    localparam int TAG_BITS_DEF = 16;
    localparam int PRIORITY_BITS_DEF = 16;

    localparam logic [1:0] KIND_ENQ = 2'd0;
    localparam logic [1:0] KIND_DEQ = 2'd1;
    localparam logic [1:0] KIND_CHG = 2'd2;
    localparam logic [1:0] KIND_CLR = 2'd3;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_EMPTY = 3'd1;
    localparam logic [2:0] ST_RAISED = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL = 3'd4;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;       // latch input item, reset index
        logic scan_find;  // compare tag at index
        logic scan_pos;   // compare priority at index
        logic shift_dn;   // slot[idx] <= slot[idx+1]
        logic shift_up;   // slot[idx] <= slot[idx-1]
        logic write_new;  // slot[idx] <= new entry
        logic cnt_inc;
        logic cnt_dec;
        logic cnt_clr;
        logic idx_inc;
        logic idx_dec;
        logic idx_to_cnt;
        logic rd_head;    // read slot 0 into head registers
    } spq_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic [1:0] kind;
        logic       full;
        logic       empty;
        logic       idx_at_end;   // idx >= count
        logic       idx_at_last;  // idx + 1 >= count
        logic       idx_zero;
        logic       tag_hit;
        logic       prio_gt_req;  // req > slot prio
        logic       prio_lt_req;  // req < slot prio
        logic       prev_le;      // prio of slot idx-1 <= new prio
    } spq_sts_t;
endpackage

// ===== hw/rtl/spq_datapath.sv =====
// Datapath of the priority queue: slot memory, count, index and compares.
module spq_datapath import spq_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  spq_cmd_t                 cmd,
    output spq_sts_t                 sts,
    input  logic [1:0]               in_kind,
    input  logic [TAG_BITS-1:0]      in_tag,
    input  logic [PRIORITY_BITS-1:0] in_prio,
    output logic [$clog2(CAPACITY+1)-1:0] count,
    output logic [TAG_BITS-1:0]      head_tag,
    output logic [PRIORITY_BITS-1:0] head_prio
);
    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [TAG_BITS-1:0]      val_mem [CAPACITY];
    logic [PRIORITY_BITS-1:0] pri_mem [CAPACITY];
    logic [1:0]               kind_reg;
    logic [TAG_BITS-1:0]      tag_reg;
    logic [PRIORITY_BITS-1:0] prio_reg;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic [CW-1:0]            idx_reg, idx_next;
    logic [TAG_BITS-1:0]      head_tag_reg;
    logic [PRIORITY_BITS-1:0] head_prio_reg;
    logic [IW-1:0]            ia, ia_p1, ia_m1;

    assign ia    = idx_reg[IW-1:0];
    assign ia_p1 = ia + IW'(1);
    assign ia_m1 = ia - IW'(1);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_clr)
        begin
            cnt_next = '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
        idx_next = idx_reg;
        if (cmd.load)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_to_cnt)
        begin
            idx_next = cnt_reg;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + CW'(1);
        end
        else if (cmd.idx_dec)
        begin
            idx_next = idx_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
            kind_reg <= KIND_ENQ;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
            if (cmd.load)
            begin
                kind_reg <= in_kind;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tag_reg  <= in_tag;
            prio_reg <= in_prio;
        end
        if (cmd.shift_dn)
        begin
            val_mem[ia] <= val_mem[ia_p1];
            pri_mem[ia] <= pri_mem[ia_p1];
        end
        else if (cmd.shift_up)
        begin
            val_mem[ia] <= val_mem[ia_m1];
            pri_mem[ia] <= pri_mem[ia_m1];
        end
        else if (cmd.write_new)
        begin
            val_mem[ia] <= tag_reg;
            pri_mem[ia] <= prio_reg;
        end
        if (cmd.rd_head)
        begin
            head_tag_reg  <= val_mem[0];
            head_prio_reg <= pri_mem[0];
        end
    end

    always_comb
    begin
        sts = '0;
        sts.kind        = kind_reg;
        sts.full        = (cnt_reg == CW'(CAPACITY));
        sts.empty       = (cnt_reg == '0);
        sts.idx_at_end  = (idx_reg >= cnt_reg);
        sts.idx_at_last = ((idx_reg + CW'(1)) >= cnt_reg);
        sts.idx_zero    = (idx_reg == '0);
        sts.tag_hit     = (val_mem[ia] == tag_reg);
        sts.prio_gt_req = (prio_reg > pri_mem[ia]);
        sts.prio_lt_req = (prio_reg < pri_mem[ia]);
        sts.prev_le     = (pri_mem[ia_m1] <= prio_reg);
    end

    assign count     = cnt_reg;
    assign head_tag  = head_tag_reg;
    assign head_prio = head_prio_reg;
endmodule

// ===== hw/rtl/spq_ctrl.sv =====
// Controller state machine that sequences the queue operations.
module spq_ctrl import spq_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  spq_sts_t sts,
    output spq_cmd_t cmd,
    output logic     busy,
    output logic     done,
    output logic [2:0] status
);
    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_DISP   = 8'b00000010,
        S_FIND   = 8'b00000100,
        S_REM    = 8'b00001000,
        S_INSRCH = 8'b00010000,
        S_INSHFT = 8'b00100000,
        S_HEAD   = 8'b01000000,
        S_DONE   = 8'b10000000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] st_reg, st_next;
    logic       reins_reg, reins_next;

    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        reins_next = reins_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    st_next    = ST_OK;
                    reins_next = 1'b0;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (sts.kind)
                    KIND_ENQ:
                    begin
                        if (sts.full)
                        begin
                            st_next    = ST_FULL;
                            state_next = S_HEAD;
                        end
                        else
                        begin
                            state_next = S_INSRCH;
                        end
                    end
                    KIND_DEQ:
                    begin
                        if (sts.empty)
                        begin
                            st_next    = ST_EMPTY;
                            state_next = S_HEAD;
                        end
                        else
                        begin
                            state_next = S_REM;
                        end
                    end
                    KIND_CHG:
                    begin
                        state_next = S_FIND;
                    end
                    default:
                    begin
                        cmd.cnt_clr = 1'b1;
                        state_next  = S_HEAD;
                    end
                endcase
            end
            S_FIND:
            begin
                if (sts.idx_at_end)
                begin
                    st_next    = ST_NOT_FOUND;
                    state_next = S_HEAD;
                end
                else if (sts.tag_hit)
                begin
                    if (sts.prio_gt_req)
                    begin
                        st_next    = ST_RAISED;
                        state_next = S_HEAD;
                    end
                    else if (sts.prio_lt_req)
                    begin
                        reins_next = 1'b1;
                        state_next = S_REM;
                    end
                    else
                    begin
                        state_next = S_HEAD;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_REM:
            begin
                if (sts.idx_at_last)
                begin
                    cmd.cnt_dec = 1'b1;
                    cmd.load    = 1'b0;
                    state_next  = reins_reg ? S_INSRCH : S_HEAD;
                end
                else
                begin
                    cmd.shift_dn = 1'b1;
                    cmd.idx_inc  = 1'b1;
                end
            end
            S_INSRCH:
            begin
                cmd.idx_to_cnt = 1'b1;
                state_next     = S_INSHFT;
            end
            S_INSHFT:
            begin
                // Walk down from the tail, moving each entry of a larger
                // priority up by one, and write the new entry behind the
                // last one whose priority is not larger.
                if (sts.idx_zero || sts.prev_le)
                begin
                    cmd.write_new = 1'b1;
                    cmd.cnt_inc   = 1'b1;
                    state_next    = S_HEAD;
                end
                else
                begin
                    cmd.shift_up = 1'b1;
                    cmd.idx_dec  = 1'b1;
                end
            end
            S_HEAD:
            begin
                cmd.rd_head = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg    <= ST_OK;
            reins_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
            reins_reg <= reins_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = (state_reg == S_DONE);
    assign status = st_reg;
endmodule

// ===== hw/rtl/stable_priority_queue_decrease_key.sv =====
// Top level of the stable priority queue with change priority.
// One transfer in gives one transfer out; the slot scan and shift loop in
// the datapath moves one slot per cycle, and one operation is in flight
// at a time.
// The result sits in an output register; the next input waits on it and on the controller being idle.
// rst_n clears the count, the controller and the output valid at once;
// slot contents stay undefined until written.
module stable_priority_queue_decrease_key import spq_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // kind[1:0], value_tag[17:2], priority_req[33:18], zero pad to 40 bits
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[2:0], dequeued_value[18:3], entry_total[23:19], queue_empty[24],
    // head_value[40:25], head_priority[56:41], zero pad to 64 bits
    output logic [63:0] m_tdata
);
    localparam int CW = $clog2(CAPACITY + 1);

    spq_cmd_t cmd;
    spq_sts_t sts;
    logic start, busy, done;
    logic [2:0] st;
    logic [CW-1:0] count;
    logic [TAG_BITS-1:0] head_tag;
    logic [PRIORITY_BITS-1:0] head_prio;
    logic [TAG_BITS-1:0] deq_reg;
    logic out_valid_reg;
    logic [63:0] out_data_reg;
    logic [15:0] deq16, htag16, hpri16;
    logic [4:0] cnt5;

    // A new transfer is taken when the controller is idle and the output
    // register is free (or is being drained in the same cycle).
    assign s_tready = !busy && (!out_valid_reg || m_tready);
    assign start    = s_tvalid && s_tready;

    spq_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .sts(sts), .cmd(cmd),
        .busy(busy), .done(done), .status(st)
    );

    spq_datapath #(
        .CAPACITY(CAPACITY), .TAG_BITS(TAG_BITS), .PRIORITY_BITS(PRIORITY_BITS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .in_kind(s_tdata[1:0]),
        .in_tag(TAG_BITS'(s_tdata[17:2])),
        .in_prio(PRIORITY_BITS'(s_tdata[33:18])),
        .count(count), .head_tag(head_tag), .head_prio(head_prio)
    );

    // The head slot is the entry being removed when a dequeue starts. The
    // head registers still hold it in the first removal cycle, whether the
    // removal shifts the queue down or only drops the last entry.
    always_ff @(posedge clk)
    begin
        if ((cmd.shift_dn || cmd.cnt_dec) && sts.idx_zero && sts.kind == KIND_DEQ)
        begin
            deq_reg <= head_tag;
        end
        else if (cmd.load)
        begin
            deq_reg <= '0;
        end
    end

    assign deq16  = 16'(deq_reg);
    assign htag16 = (count == '0) ? 16'd0 : 16'(head_tag);
    assign hpri16 = (count == '0) ? 16'd0 : 16'(head_prio);
    assign cnt5   = 5'(count);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_data_reg <= {7'd0, hpri16, htag16, (count == '0), cnt5, deq16, st};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
endmodule

// ===== hw/rtl/spq_checker.sv =====
// Port-level checker for the priority queue, bound to the top level.
`include "stable_priority_queue_decrease_key_macros.svh"
module spq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);
    `SPQ_ASSERT_IMPL(a_empty_flag, clk, rst_n, m_tvalid, (m_tdata[24] == (m_tdata[23:19] == 5'd0)))
    `SPQ_ASSERT_IMPL(a_cnt_range, clk, rst_n, m_tvalid, (m_tdata[23:19] <= 5'd16))
    `SPQ_ASSERT_NEXT(a_no_accept_after, clk, rst_n, (s_tvalid && s_tready), !s_tready)
    `SPQ_ASSERT_NEXT(a_hold, clk, rst_n, (m_tvalid && !m_tready), (m_tvalid && $stable(m_tdata)))
endmodule

bind stable_priority_queue_decrease_key spq_checker u_spq_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// ===== test/tb_stable_priority_queue_decrease_key.sv =====
// Testbench for the stable priority queue: directed table plus random traffic with a predictor.
module tb_stable_priority_queue_decrease_key;
    import spq_pkg::*;

    localparam int SLOTS = 16;
    localparam int RANDOM_OPS = 1700;

    // One queue operation as it travels on the slave side.
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] tag;
        logic [15:0] prio;
    } queue_op_t;

    // One result as it travels on the master side, highest field first.
    typedef struct packed {
        logic [15:0] head_prio;
        logic [15:0] head_tag;
        logic        empty;
        logic [4:0]  total;
        logic [15:0] deq_tag;
        logic [2:0]  status;
    } queue_rsp_t;

    // A directed row; when typed is set the expected result is written out in full.
    typedef struct {
        queue_op_t  op;
        bit         typed;
        queue_rsp_t rsp;
    } table_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;

    stable_priority_queue_decrease_key DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Predictor copy of the queue contents, kept in service order with slot 0 at the head.
    logic [15:0] model_tag [SLOTS];
    logic [15:0] model_prio [SLOTS];
    int          model_count;

    // Results still to arrive, oldest first.
    queue_rsp_t  pending_rsp [$];

    int          error_count;
    int          rsp_count;
    int          op_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          kind_seen [4];
    int          status_seen [5];

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Safety net: a stuck handshake must not hang the run.
    initial
    begin
        #4000000;
        $display("timeout waiting on the queue handshakes");
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch on result %0d: %s got %0h expected %0h", rsp_count, what, got, want);
        error_count++;
    endtask

    function automatic void drop_slot(input int pos);
        for (int i = pos; i + 1 < model_count; i++)
        begin
            model_tag[i]  = model_tag[i + 1];
            model_prio[i] = model_prio[i + 1];
        end
        model_count--;
    endfunction

    // New entries go behind every entry of the same or a smaller priority.
    function automatic void place_sorted(input logic [15:0] tag, input logic [15:0] prio);
        int pos;
        pos = 0;
        while (pos < model_count && model_prio[pos] <= prio)
            pos++;
        for (int i = model_count; i > pos; i--)
        begin
            model_tag[i]  = model_tag[i - 1];
            model_prio[i] = model_prio[i - 1];
        end
        model_tag[pos]  = tag;
        model_prio[pos] = prio;
        model_count++;
    endfunction

    function automatic queue_rsp_t apply_queue_op(input queue_op_t op);
        queue_rsp_t rsp;
        int         hit;
        rsp = '0;
        rsp.status = ST_OK;
        case (op.kind)
            KIND_ENQ:
                if (model_count >= SLOTS)
                    rsp.status = ST_FULL;
                else
                    place_sorted(op.tag, op.prio);
            KIND_DEQ:
                if (model_count == 0)
                    rsp.status = ST_EMPTY;
                else
                begin
                    rsp.deq_tag = model_tag[0];
                    drop_slot(0);
                end
            KIND_CHG:
            begin
                // The first match in service order is the one that moves.
                hit = -1;
                for (int i = 0; i < model_count; i++)
                    if (hit < 0 && model_tag[i] == op.tag)
                        hit = i;
                if (hit < 0)
                    rsp.status = ST_NOT_FOUND;
                else if (op.prio > model_prio[hit])
                    rsp.status = ST_RAISED;
                else if (op.prio < model_prio[hit])
                begin
                    drop_slot(hit);
                    place_sorted(op.tag, op.prio);
                end
            end
            default:
                model_count = 0;
        endcase
        rsp.total = model_count[4:0];
        rsp.empty = (model_count == 0);
        if (model_count != 0)
        begin
            rsp.head_tag  = model_tag[0];
            rsp.head_prio = model_prio[0];
        end
        return rsp;
    endfunction

    // Drives one operation and waits for its transfer; the sender may idle first.
    // Valid stays up after a transfer until the next idle cycle or the next item.
    task automatic send_op(input queue_op_t op);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, op.prio, op.tag, op.kind};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        kind_seen[op.kind]++;
        op_count++;
    endtask

    task automatic send_checked(input queue_op_t op);
        pending_rsp.push_back(apply_queue_op(op));
        send_op(op);
    endtask

    // Random ready on the master side, one decision per clock edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    // Compare every accepted result, field by field, with the oldest expectation.
    always @(posedge clk)
    begin
        queue_rsp_t got;
        queue_rsp_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[56:0];
            if (pending_rsp.size() == 0)
            begin
                $display("result %0d arrived with nothing expected", rsp_count);
                error_count++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", 16'(got.status), 16'(want.status));
                else if (got.status <= ST_FULL)
                    status_seen[got.status]++;
                if (got.deq_tag != want.deq_tag)
                    report_mismatch("dequeued_value", got.deq_tag, want.deq_tag);
                if (got.total != want.total)
                    report_mismatch("entry_total", 16'(got.total), 16'(want.total));
                if (got.empty != want.empty)
                    report_mismatch("queue_empty", 16'(got.empty), 16'(want.empty));
                if (got.head_tag != want.head_tag)
                    report_mismatch("head_value", got.head_tag, want.head_tag);
                if (got.head_prio != want.head_prio)
                    report_mismatch("head_priority", got.head_prio, want.head_prio);
                if (m_tdata[63:57] != '0)
                    report_mismatch("pad bits", 16'(m_tdata[63:57]), 16'd0);
            end
            rsp_count++;
        end
    end

    function automatic queue_op_t mk(input logic [1:0] kind, input logic [15:0] tag,
                                     input logic [15:0] prio);
        queue_op_t op;
        op.kind = kind;
        op.tag  = tag;
        op.prio = prio;
        return op;
    endfunction

    function automatic queue_rsp_t rs(input logic [2:0] st, input logic [15:0] dq,
                                      input int total, input logic [15:0] ht,
                                      input logic [15:0] hp);
        queue_rsp_t rsp;
        rsp.status    = st;
        rsp.deq_tag   = dq;
        rsp.total     = total[4:0];
        rsp.empty     = (total == 0);
        rsp.head_tag  = ht;
        rsp.head_prio = hp;
        return rsp;
    endfunction

    // Tags are drawn from a small pool most of the time so that change priority finds them.
    function automatic logic [15:0] pick_tag();
        if ($urandom_range(9, 0) < 8)
            return 16'($urandom_range(7, 0)) ^ 16'hA5A0;
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] pick_prio();
        case ($urandom_range(3, 0))
            0: return 16'($urandom_range(3, 0));
            1: return 16'hFFFF - 16'($urandom_range(3, 0));
            2: return 16'($urandom_range(40, 0)) * 16'd1000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Random operation; the mix leans toward enqueue while the queue is short.
    function automatic queue_op_t random_op();
        queue_op_t op;
        int        roll;
        int        hit;
        roll = $urandom_range(99, 0);
        op.tag  = pick_tag();
        op.prio = pick_prio();
        if (roll < (model_count < 12 ? 45 : 30))
            op.kind = KIND_ENQ;
        else if (roll < 65)
            op.kind = KIND_DEQ;
        else if (roll < 97)
        begin
            op.kind = KIND_CHG;
            // Usually aim at a held entry, and mostly keep or lower its priority.
            if (model_count != 0 && $urandom_range(3, 0) != 0)
            begin
                hit = $urandom_range(model_count - 1, 0);
                op.tag = model_tag[hit];
                case ($urandom_range(3, 0))
                    0: op.prio = model_prio[hit];
                    1: op.prio = model_prio[hit] + 16'($urandom_range(50, 1));
                    default: op.prio = model_prio[hit] - 16'($urandom_range(
                        model_prio[hit] < 50 ? model_prio[hit] : 50, 0));
                endcase
            end
        end
        else
            op.kind = KIND_CLR;
        return op;
    endfunction

    initial
    begin
        table_row_t directed [$];
        queue_op_t  op;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        error_count   = 0;
        rsp_count     = 0;
        op_count      = 0;
        model_count   = 0;
        send_idle_pct = 13;
        recv_idle_pct = 66;
        foreach (kind_seen[i])
            kind_seen[i] = 0;
        foreach (status_seen[i])
            status_seen[i] = 0;

        // Directed table: empty queue cases, extremes, every change-priority outcome, full.
        directed.push_back('{mk(KIND_DEQ, 16'h0000, 16'h0000), 1, rs(ST_EMPTY, 0, 0, 0, 0)});
        directed.push_back('{mk(KIND_CHG, 16'h1234, 16'h0005), 1,
                             rs(ST_NOT_FOUND, 0, 0, 0, 0)});
        directed.push_back('{mk(KIND_CLR, 16'hFFFF, 16'hFFFF), 1, rs(ST_OK, 0, 0, 0, 0)});
        directed.push_back('{mk(KIND_ENQ, 16'hFFFF, 16'hFFFF), 1,
                             rs(ST_OK, 0, 1, 16'hFFFF, 16'hFFFF)});
        directed.push_back('{mk(KIND_ENQ, 16'h0000, 16'h0000), 1,
                             rs(ST_OK, 0, 2, 16'h0000, 16'h0000)});
        directed.push_back('{mk(KIND_ENQ, 16'h00AA, 16'h0010), 0, '0});
        directed.push_back('{mk(KIND_ENQ, 16'h00BB, 16'h0010), 0, '0});
        directed.push_back('{mk(KIND_ENQ, 16'h00AA, 16'h0020), 0, '0});
        // Equal priority leaves the queue alone; a larger one is refused.
        directed.push_back('{mk(KIND_CHG, 16'h00AA, 16'h0010), 0, '0});
        directed.push_back('{mk(KIND_CHG, 16'h00AA, 16'h0011), 0, '0});
        // A smaller one moves the first match to the tail of its new group.
        directed.push_back('{mk(KIND_CHG, 16'h00BB, 16'h0000), 0, '0});
        directed.push_back('{mk(KIND_CHG, 16'h00AA, 16'h0000), 0, '0});
        directed.push_back('{mk(KIND_CHG, 16'h5555, 16'h0000), 0, '0});
        directed.push_back('{mk(KIND_DEQ, 16'h0000, 16'h0000), 0, '0});
        directed.push_back('{mk(KIND_DEQ, 16'h0000, 16'h0000), 0, '0});
        for (int i = 0; i < 12; i++)
            directed.push_back('{mk(KIND_ENQ, 16'(16'hAAAA ^ i), 16'(16'h5555 + i)), 0, '0});
        directed.push_back('{mk(KIND_ENQ, 16'h7777, 16'h0001), 0, '0});
        directed.push_back('{mk(KIND_CLR, 16'h0000, 16'h0000), 1, rs(ST_OK, 0, 0, 0, 0)});

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            // The predictor also tracks typed rows so its state stays in step.
            op = directed[i].op;
            if (directed[i].typed)
            begin
                void'(apply_queue_op(op));
                pending_rsp.push_back(directed[i].rsp);
                send_op(op);
            end
            else
                send_checked(op);
        end

        // Fill to capacity with random content, then one enqueue too many.
        while (model_count < SLOTS)
            send_checked(mk(KIND_ENQ, pick_tag(), pick_prio()));
        send_checked(mk(KIND_ENQ, 16'h0F0F, 16'h0000));

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 66 : 0;
            recv_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 13 : 0;
            for (int n = 0; n < RANDOM_OPS / 3; n++)
                send_checked(random_op());
        end
        s_tvalid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (2 * SLOTS + 20) @(posedge clk);

        $display("%0d operations: %0d enqueue, %0d dequeue, %0d change, %0d clear",
                 op_count, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
        $display("status ok %0d, empty %0d, raised %0d, not found %0d, full %0d; %0d errors",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], error_count);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
